/* src/led_double_pulse_breather_top_assert.svh */
// assertion macros for the breather top level
`ifndef LED_DOUBLE_PULSE_BREATHER_TOP_ASSERT_SVH
`define LED_DOUBLE_PULSE_BREATHER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LDPB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define LDPB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ldpb_pkg.sv */
package ldpb_pkg;

    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int PERIOD_BITS = 16;
    localparam int PULSE_BITS = 8;
    localparam int MODE_BITS = 2;
    localparam int OUT_DUTY_BITS = 8;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_PERIOD = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PAUSE_PERIOD = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BLINK_PERIOD = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PULSES_PER_GROUP = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_FORCE_MODE = 3'd4;

    // force modes; the unused code behaves as forced on
    localparam logic [MODE_BITS-1:0] FORCE_NORMAL = 2'd0;
    localparam logic [MODE_BITS-1:0] FORCE_OFF = 2'd1;
    localparam logic [MODE_BITS-1:0] FORCE_ON = 2'd2;

    // register reset values
    localparam logic [PERIOD_BITS-1:0] STEP_PERIOD_RST = 16'd4;
    localparam logic [PERIOD_BITS-1:0] PAUSE_PERIOD_RST = 16'd1000;
    localparam logic [PERIOD_BITS-1:0] BLINK_PERIOD_RST = 16'd150;
    localparam logic [PULSE_BITS-1:0] PULSES_PER_GROUP_RST = 8'd2;

    typedef struct packed {
        logic [PERIOD_BITS-1:0] step_period;
        logic [PERIOD_BITS-1:0] pause_period;
        logic [PERIOD_BITS-1:0] blink_period;
        logic [PULSE_BITS-1:0]  pulses_per_group;
        logic [MODE_BITS-1:0]   force_mode;
    } cfg_t;

endpackage

/* src/ldpb_cfg.sv */
module ldpb_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ldpb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [ldpb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output ldpb_pkg::cfg_t                      cfg
);

    ldpb_pkg::cfg_t cfg_reg;
    ldpb_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                ldpb_pkg::REG_STEP_PERIOD:
                    cfg_next.step_period = cfg_data;
                ldpb_pkg::REG_PAUSE_PERIOD:
                    cfg_next.pause_period = cfg_data;
                ldpb_pkg::REG_BLINK_PERIOD:
                    cfg_next.blink_period = cfg_data;
                ldpb_pkg::REG_PULSES_PER_GROUP:
                    cfg_next.pulses_per_group = cfg_data[ldpb_pkg::PULSE_BITS-1:0];
                ldpb_pkg::REG_FORCE_MODE:
                    cfg_next.force_mode = cfg_data[ldpb_pkg::MODE_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_period <= ldpb_pkg::STEP_PERIOD_RST;
            cfg_reg.pause_period <= ldpb_pkg::PAUSE_PERIOD_RST;
            cfg_reg.blink_period <= ldpb_pkg::BLINK_PERIOD_RST;
            cfg_reg.pulses_per_group <= ldpb_pkg::PULSES_PER_GROUP_RST;
            cfg_reg.force_mode <= ldpb_pkg::FORCE_NORMAL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* src/ldpb_core.sv */
module ldpb_core #(
    parameter int DUTY_BITS = 8,
    parameter int TIMER_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 fault,
    input  ldpb_pkg::cfg_t                       cfg,
    output logic [ldpb_pkg::OUT_DUTY_BITS-1:0]   duty,
    output logic                                 led_on
);

    localparam int CMP_W = (TIMER_BITS > ldpb_pkg::PERIOD_BITS) ?
                           TIMER_BITS : ldpb_pkg::PERIOD_BITS;
    localparam logic [DUTY_BITS-1:0] FULL = {DUTY_BITS{1'b1}};
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    logic [DUTY_BITS-1:0]            level_reg, level_next;
    logic                            going_up_reg, going_up_next;
    logic [ldpb_pkg::PULSE_BITS-1:0] pulses_done_reg, pulses_done_next;
    logic                            pausing_reg, pausing_next;
    logic [TIMER_BITS-1:0]           since_step_reg, since_step_next;
    logic [TIMER_BITS-1:0]           since_pause_reg, since_pause_next;
    logic [TIMER_BITS-1:0]           since_toggle_reg, since_toggle_next;
    logic                            blink_phase_reg, blink_phase_next;

    logic [TIMER_BITS-1:0]           step_inc, pause_inc, toggle_inc;
    logic [ldpb_pkg::PULSE_BITS-1:0] pulses_inc;
    logic [DUTY_BITS-1:0]            level_up, level_dn;
    logic [DUTY_BITS-1:0]            duty_val;
    logic                            run;

    // saturating elapsed counters
    assign step_inc = (since_step_reg == TMAX) ? TMAX : since_step_reg + 1'b1;
    assign pause_inc = (since_pause_reg == TMAX) ? TMAX : since_pause_reg + 1'b1;
    assign toggle_inc = (since_toggle_reg == TMAX) ? TMAX : since_toggle_reg + 1'b1;
    assign pulses_inc = pulses_done_reg + 1'b1;
    assign level_up = (level_reg == FULL) ? FULL : level_reg + 1'b1;
    assign level_dn = (level_reg == '0) ? '0 : level_reg - 1'b1;

    always_comb
    begin
        level_next = level_reg;
        going_up_next = going_up_reg;
        pulses_done_next = pulses_done_reg;
        pausing_next = pausing_reg;
        since_step_next = since_step_reg;
        since_pause_next = since_pause_reg;
        since_toggle_next = since_toggle_reg;
        blink_phase_next = blink_phase_reg;
        run = 1'b0;
        duty_val = level_reg;

        unique case (cfg.force_mode)
            ldpb_pkg::FORCE_OFF:
                duty_val = '0;
            ldpb_pkg::FORCE_NORMAL:
            begin
                since_step_next = step_inc;
                since_pause_next = pause_inc;
                since_toggle_next = toggle_inc;
                if (fault)
                begin
                    // fault blink overrides the ramp
                    if (CMP_W'(toggle_inc) >= CMP_W'(cfg.blink_period))
                    begin
                        since_toggle_next = '0;
                        blink_phase_next = ~blink_phase_reg;
                        level_next = blink_phase_reg ? '0 : FULL;
                    end
                end
                else
                begin
                    run = 1'b1;
                    if (pausing_reg)
                    begin
                        if (CMP_W'(pause_inc) >= CMP_W'(cfg.pause_period))
                            pausing_next = 1'b0;
                        else
                            run = 1'b0;
                    end
                    if (run && (CMP_W'(step_inc) >= CMP_W'(cfg.step_period)))
                    begin
                        since_step_next = '0;
                        if (going_up_reg)
                        begin
                            level_next = level_up;
                            if (level_up == FULL)
                                going_up_next = 1'b0;
                        end
                        else
                        begin
                            level_next = level_dn;
                            if (level_dn == '0)
                            begin
                                // bottom of a triangle ends one pulse
                                going_up_next = 1'b1;
                                pulses_done_next = pulses_inc;
                                if (pulses_inc >= cfg.pulses_per_group)
                                begin
                                    pulses_done_next = '0;
                                    pausing_next = 1'b1;
                                    since_pause_next = '0;
                                end
                            end
                        end
                    end
                end
                duty_val = level_next;
            end
            default:
                duty_val = FULL;
        endcase
    end

    assign duty = ldpb_pkg::OUT_DUTY_BITS'(duty_val);
    assign led_on = |duty_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            going_up_reg <= 1'b1;
            pulses_done_reg <= '0;
            pausing_reg <= 1'b0;
            since_step_reg <= '0;
            since_pause_reg <= '0;
            since_toggle_reg <= '0;
            blink_phase_reg <= 1'b0;
        end
        else if (en)
        begin
            level_reg <= level_next;
            going_up_reg <= going_up_next;
            pulses_done_reg <= pulses_done_next;
            pausing_reg <= pausing_next;
            since_step_reg <= since_step_next;
            since_pause_reg <= since_pause_next;
            since_toggle_reg <= since_toggle_next;
            blink_phase_reg <= blink_phase_next;
        end
    end

endmodule

/* src/led_double_pulse_breather_top.sv */
// led double-pulse breather
// slave stream: one request per millisecond tick, tdata[0] = fault
// master stream: one result per request, tdata[7:0] = duty, tdata[8] = led_on
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high, write only while the stream path is idle
// path: an accepted request waits in the input register; when the output
//   register is free or emptying, the core computes its result into the
//   output register, which drives m_axis_tvalid
// throughput: one request per cycle while the receiver keeps tready high;
//   the core updates its state between the input and output registers
// stall: when the receiver holds tready low, the output register keeps its
//   result and the input register holds one more request; s_axis_tready falls
//   only when both are full
// reset: rst_n is asynchronous, active low; both pipeline stages empty, the
//   ramp starts at zero going up, registers return to their default values
module led_double_pulse_breather_top #(
    parameter int DUTY_BITS = 8,
    parameter int TIMER_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [0] fault, rest zero
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [15:0]                         m_axis_tdata,   // [7:0] duty, [8] led_on
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ldpb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [ldpb_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    `include "led_double_pulse_breather_top_assert.svh"

    ldpb_pkg::cfg_t cfg;

    // input stage
    logic in_valid_reg, in_valid_next;
    logic fault_reg;
    // output stage
    logic out_valid_reg, out_valid_next;
    logic [ldpb_pkg::OUT_DUTY_BITS-1:0] out_duty_reg;
    logic out_led_reg;

    logic in_take;
    logic advance;
    logic [ldpb_pkg::OUT_DUTY_BITS-1:0] core_duty;
    logic core_led;

    ldpb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // the held request moves on whenever the output register is free or emptying
    assign advance = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take = s_axis_tvalid && s_axis_tready;

    ldpb_core #(
        .DUTY_BITS  (DUTY_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .fault  (fault_reg),
        .cfg    (cfg),
        .duty   (core_duty),
        .led_on (core_led)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            fault_reg <= s_axis_tdata[0];
        if (advance)
        begin
            out_duty_reg <= core_duty;
            out_led_reg <= core_led;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {7'd0, out_led_reg, out_duty_reg};

    // both stages full and receiver stalled: no new request may enter
    `LDPB_ASSERT_NOW(a_full_blocks, in_valid_reg && out_valid_reg && !m_axis_tready,
        !s_axis_tready, "input accepted while pipeline is full")
    // a held request is not dropped before it reaches the output stage
    `LDPB_ASSERT_NEXT(a_held_request, in_valid_reg && !advance,
        in_valid_reg, "held request lost")
    // forced off always yields a dark result
    `LDPB_ASSERT_NEXT(a_forced_off, advance && (cfg.force_mode == ldpb_pkg::FORCE_OFF),
        (m_axis_tdata[7:0] == 8'd0) && !m_axis_tdata[8], "forced off result not dark")

endmodule

/* test/ldpb_breath_checker.sv */
module ldpb_breath_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [0] fault
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [15:0]                         m_axis_tdata,   // [7:0] duty, [8] led_on
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [ldpb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [ldpb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                  failures,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ldpb_pkg::PERIOD_BITS-1:0]   TIMER_TOP = '1;
    localparam logic [ldpb_pkg::OUT_DUTY_BITS-1:0] DUTY_TOP = '1;

    typedef struct packed {
        logic [ldpb_pkg::OUT_DUTY_BITS-1:0] duty;
        logic                               led_on;
    } glow_sample_t;

    glow_sample_t expected_glow[$];

    ldpb_pkg::cfg_t                     regs;
    logic [ldpb_pkg::OUT_DUTY_BITS-1:0] glow;
    logic                               rising;
    logic [ldpb_pkg::PULSE_BITS-1:0]    triangles_done;
    logic                               dark;
    logic [ldpb_pkg::PERIOD_BITS-1:0]   step_age;
    logic [ldpb_pkg::PERIOD_BITS-1:0]   dark_age;
    logic [ldpb_pkg::PERIOD_BITS-1:0]   blink_age;
    logic                               blink_high;

    function automatic logic [ldpb_pkg::PERIOD_BITS-1:0] age_up(
        input logic [ldpb_pkg::PERIOD_BITS-1:0] v);
        return (v == TIMER_TOP) ? v : v + 1'b1;
    endfunction

    // one tick of the breathing pattern, state is updated in place
    task automatic breathe(input logic fault,
                           output logic [ldpb_pkg::OUT_DUTY_BITS-1:0] duty);
        logic ramp_free;
        ramp_free = 1'b1;
        if (regs.force_mode == ldpb_pkg::FORCE_OFF)
            duty = '0;
        else if (regs.force_mode != ldpb_pkg::FORCE_NORMAL)
            duty = DUTY_TOP;
        else
        begin
            step_age = age_up(step_age);
            dark_age = age_up(dark_age);
            blink_age = age_up(blink_age);
            if (fault)
            begin
                if (blink_age >= regs.blink_period)
                begin
                    blink_age = '0;
                    blink_high = !blink_high;
                    glow = blink_high ? DUTY_TOP : '0;
                end
            end
            else
            begin
                if (dark)
                begin
                    if (dark_age >= regs.pause_period)
                        dark = 1'b0;
                    else
                        ramp_free = 1'b0;
                end
                if (ramp_free && step_age >= regs.step_period)
                begin
                    step_age = '0;
                    if (rising)
                    begin
                        if (glow != DUTY_TOP)
                            glow = glow + 1'b1;
                        if (glow == DUTY_TOP)
                            rising = 1'b0;
                    end
                    else
                    begin
                        if (glow != '0)
                            glow = glow - 1'b1;
                        if (glow == '0)
                        begin
                            rising = 1'b1;
                            triangles_done = triangles_done + 1'b1;
                            if (triangles_done >= regs.pulses_per_group)
                            begin
                                triangles_done = '0;
                                dark = 1'b1;
                                dark_age = '0;
                            end
                        end
                    end
                end
            end
            duty = glow;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        glow_sample_t                       want;
        glow_sample_t                       seen;
        logic [ldpb_pkg::OUT_DUTY_BITS-1:0] duty;
        if (!rst_n)
        begin
            regs.step_period = ldpb_pkg::STEP_PERIOD_RST;
            regs.pause_period = ldpb_pkg::PAUSE_PERIOD_RST;
            regs.blink_period = ldpb_pkg::BLINK_PERIOD_RST;
            regs.pulses_per_group = ldpb_pkg::PULSES_PER_GROUP_RST;
            regs.force_mode = ldpb_pkg::FORCE_NORMAL;
            glow = '0;
            rising = 1'b1;
            triangles_done = '0;
            dark = 1'b0;
            step_age = '0;
            dark_age = '0;
            blink_age = '0;
            blink_high = 1'b0;
            expected_glow.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ldpb_pkg::REG_STEP_PERIOD:
                        regs.step_period = cfg_data;
                    ldpb_pkg::REG_PAUSE_PERIOD:
                        regs.pause_period = cfg_data;
                    ldpb_pkg::REG_BLINK_PERIOD:
                        regs.blink_period = cfg_data;
                    ldpb_pkg::REG_PULSES_PER_GROUP:
                        regs.pulses_per_group = cfg_data[ldpb_pkg::PULSE_BITS-1:0];
                    ldpb_pkg::REG_FORCE_MODE:
                        regs.force_mode = cfg_data[ldpb_pkg::MODE_BITS-1:0];
                    default: ;
                endcase
            end
            // results first, so a result can never match a request of the same edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.duty = m_axis_tdata[7:0];
                seen.led_on = m_axis_tdata[8];
                if (expected_glow.size() == 0)
                begin
                    $display("%0t: unexpected result duty %0d led_on %0d", $realtime,
                             seen.duty, seen.led_on);
                    failures <= failures + 1;
                end
                else
                begin
                    want = expected_glow.pop_front();
                    if (want.duty !== seen.duty || want.led_on !== seen.led_on)
                    begin
                        $display("%0t: expected duty %0d led_on %0d, got duty %0d led_on %0d",
                                 $realtime, want.duty, want.led_on, seen.duty, seen.led_on);
                        failures <= failures + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                breathe(s_axis_tdata[0], duty);
                want.duty = duty;
                want.led_on = (duty != '0);
                expected_glow.push_back(want);
            end
            pending <= expected_glow.size();
        end
    end

endmodule

/* test/tb_led_double_pulse_breather_top.sv */
module tb_led_double_pulse_breather_top;
    timeunit 1ns;
    timeprecision 1ps;

    // the spare mode code, treated by the block as forced on
    localparam logic [ldpb_pkg::MODE_BITS-1:0] FORCE_SPARE = 2'd3;
    localparam logic [ldpb_pkg::PERIOD_BITS-1:0] PERIOD_TOP = '1;
    localparam int PHASES = 10;
    localparam int PHASE_TICKS = 120;
    localparam int CYCLE_LIMIT = 300000;

    logic clk;
    logic rst_n = 1'b0;

    // tick request stream into the block
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [0] fault, rest zero

    // duty result stream out of the block
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [7:0] duty, [8] led_on

    // register write channel
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [ldpb_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [ldpb_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

    int   failures;
    int   pending;
    int   cycle_count = 0;
    int   rx_stall_left = 0;
    logic idling_on = 1'b0;

    led_double_pulse_breather_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // watches all three channels, predicts each duty and compares
    ldpb_breath_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .failures      (failures),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog, far above the slowest legal run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_led_double_pulse_breather_top: FAIL");
            $finish;
        end
    end

    // receiver side: random stall bursts while idling is on
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (rx_stall_left > 0)
        begin
            rx_stall_left <= rx_stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 9) == 0)
        begin
            rx_stall_left <= $urandom_range(0, 13);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // one register write; valid stays up so back-to-back writes need no toggle
    task automatic write_reg(input logic [ldpb_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [ldpb_pkg::CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // writes every register, only called with the stream path drained
    task automatic program_regs(input logic [ldpb_pkg::PERIOD_BITS-1:0] step_p,
                                input logic [ldpb_pkg::PERIOD_BITS-1:0] pause_p,
                                input logic [ldpb_pkg::PERIOD_BITS-1:0] blink_p,
                                input logic [ldpb_pkg::PULSE_BITS-1:0]  pulses,
                                input logic [ldpb_pkg::MODE_BITS-1:0]   mode);
        write_reg(ldpb_pkg::REG_STEP_PERIOD, step_p);
        write_reg(ldpb_pkg::REG_PAUSE_PERIOD, pause_p);
        write_reg(ldpb_pkg::REG_BLINK_PERIOD, blink_p);
        write_reg(ldpb_pkg::REG_PULSES_PER_GROUP,
                  {{(ldpb_pkg::CFG_DATA_BITS-ldpb_pkg::PULSE_BITS){1'b0}}, pulses});
        write_reg(ldpb_pkg::REG_FORCE_MODE,
                  {{(ldpb_pkg::CFG_DATA_BITS-ldpb_pkg::MODE_BITS){1'b0}}, mode});
        cfg_valid <= 1'b0;
    endtask

    // sender holds off until every result is back, then idles before returning
    task automatic let_drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // one tick request, with an optional random gap in front of it
    task automatic send_tick(input logic fault);
        if (idling_on && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, fault};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // mostly short periods so the ramp turns over, with the odd long or extreme one
    function automatic logic [ldpb_pkg::PERIOD_BITS-1:0] pick_period();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2, 3,
            4, 5:    return ldpb_pkg::PERIOD_BITS'($urandom_range(1, 3));
            6, 7:    return ldpb_pkg::PERIOD_BITS'($urandom_range(4, 40));
            8:       return ldpb_pkg::PERIOD_BITS'($urandom_range(41, 3000));
            default: return ($urandom_range(0, 1) == 0) ? PERIOD_TOP :
                            ldpb_pkg::PERIOD_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    initial
    begin
        int                              phase;
        int                              n;
        int                              fault_left;
        int                              fault_pct;
        logic                            fault_now;
        logic [ldpb_pkg::PULSE_BITS-1:0] pulses;
        logic [ldpb_pkg::MODE_BITS-1:0]  mode;
        fault_left = 0;
        fault_pct = 0;
        fault_now = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults, first without and then with a fault
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);

        // zero periods and zero pulses per group: everything acts every tick
        let_drain();
        program_regs('0, '0, '0, '0, ldpb_pkg::FORCE_NORMAL);
        repeat (3) send_tick(1'b0);
        // blink overwrites the level, then the ramp carries on from there
        repeat (3) send_tick(1'b1);
        repeat (3) send_tick(1'b0);

        // forced off, forced on and the spare code, state frozen through all
        let_drain();
        program_regs(16'd1, 16'd1, 16'd1, 8'd1, ldpb_pkg::FORCE_OFF);
        send_tick(1'b0);
        send_tick(1'b1);
        let_drain();
        program_regs(16'd1, 16'd1, 16'd1, 8'd1, ldpb_pkg::FORCE_ON);
        send_tick(1'b1);
        send_tick(1'b0);
        let_drain();
        program_regs(16'd1, 16'd1, 16'd1, 8'd1, FORCE_SPARE);
        send_tick(1'b0);
        send_tick(1'b1);

        // top of every range: the counters never reach the periods here
        let_drain();
        program_regs(PERIOD_TOP, PERIOD_TOP, PERIOD_TOP, 8'hFF, ldpb_pkg::FORCE_NORMAL);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);

        // random phases, each with its own register setting and fault density
        for (phase = 0; phase < PHASES; phase++)
        begin
            case ($urandom_range(0, 5))
                0:       pulses = '0;
                1, 2, 3: pulses = ldpb_pkg::PULSE_BITS'($urandom_range(1, 3));
                4:       pulses = 8'hFF;
                default: pulses = ldpb_pkg::PULSE_BITS'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 11))
                0:       mode = ldpb_pkg::FORCE_OFF;
                1:       mode = ldpb_pkg::FORCE_ON;
                2:       mode = FORCE_SPARE;
                default: mode = ldpb_pkg::FORCE_NORMAL;
            endcase
            case ($urandom_range(0, 4))
                0:       fault_pct = 0;
                1:       fault_pct = 5;
                2:       fault_pct = 30;
                3:       fault_pct = 70;
                default: fault_pct = 100;
            endcase
            let_drain();
            program_regs(pick_period(), pick_period(), pick_period(), pulses, mode);
            // the last phase runs at full rate on both sides
            idling_on <= (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (n = 0; n < PHASE_TICKS; n++)
            begin
                // faults come in runs, as a real load fault would
                if (fault_left == 0)
                begin
                    fault_now = ($urandom_range(0, 99) < fault_pct);
                    fault_left = $urandom_range(1, 40);
                end
                fault_left--;
                if (idling_on && $urandom_range(0, 199) == 0)
                    let_drain();
                send_tick(fault_now);
            end
        end

        let_drain();
        repeat (8) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("tb_led_double_pulse_breather_top: PASS");
        else
            $display("tb_led_double_pulse_breather_top: FAIL");
        $finish;
    end

endmodule
